// File: rtl/trpd_pkg.sv
// ----------------------------------------------------------------------------
// TGA RLE pixel decoder package
// Shared types and constants: pixel formats, register indexes, pixel records.
// ----------------------------------------------------------------------------
package trpd_pkg;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_RLE_ENABLED   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PIXEL_FORMAT  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ONE_BIT_ALPHA = 2'd2;

   localparam logic [1:0] FMT_RGB555 = 2'd0;
   localparam logic [1:0] FMT_BGR    = 2'd1;
   localparam logic [1:0] FMT_BGRA   = 2'd2;

   localparam logic [7:0] ALPHA_OPAQUE = 8'hff;

   typedef struct packed {
      logic       rle_enabled;
      logic [1:0] pixel_format;
      logic       one_bit_alpha;
   } cfg_type;

   typedef struct packed {
      logic [7:0] s0;
      logic [7:0] s1;
      logic [7:0] s2;
      logic [7:0] s3;
      logic [7:0] run_count;
   } pixel_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
      logic       alpha_valid;
      logic [7:0] run_count;
   } color_type;

   function automatic logic [1:0] last_byte_index(input logic [1:0] fmt);
      logic [1:0] idx;
      case (fmt)
         FMT_RGB555: idx = 2'd1;
         FMT_BGR:    idx = 2'd2;
         default:    idx = 2'd3;
      endcase
      return idx;
   endfunction

   function automatic logic [7:0] widen5(input logic [4:0] c);
      return {c, c[4:2]};
   endfunction

endpackage

// File: rtl/trpd_req_if.sv
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one byte of the pixel stream.
// ----------------------------------------------------------------------------
interface trpd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

// File: rtl/trpd_rsp_if.sv
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying one decoded pixel and its run count.
// ----------------------------------------------------------------------------
interface trpd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;
   logic [7:0] alpha;
   logic       alpha_valid;
   logic [7:0] run_count;

   modport source (output valid, output red, output green, output blue, output alpha,
                   output alpha_valid, output run_count, input ready);
   modport sink   (input valid, input red, input green, input blue, input alpha,
                   input alpha_valid, input run_count, output ready);
endinterface

// File: rtl/trpd_unpack.sv
// ----------------------------------------------------------------------------
// Packet and byte tracker
// Follows packet headers and gathers pixel bytes; flags each complete pixel.
// ----------------------------------------------------------------------------
module trpd_unpack (
   input  logic               clock,
   input  logic               reset,
   input  trpd_pkg::cfg_type  cfg,
   input  logic               accept,
   input  logic [7:0]         data_byte,
   output logic               pix_done,
   output trpd_pkg::pixel_type pixel
);

   typedef enum logic [1:0] {
      PH_HEADER = 2'd0,
      PH_REPEAT = 2'd1,
      PH_RAW    = 2'd2
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [7:0]  pixels_left_ff, pixels_left_in;
   logic [7:0]  repeat_len_ff, repeat_len_in;
   logic [1:0]  byte_idx_ff, byte_idx_in;
   logic [23:0] partial_ff, partial_in;
   logic [1:0]  last_idx;
   logic        take_byte;

   always_comb begin
      phase_in       = phase_ff;
      pixels_left_in = pixels_left_ff;
      repeat_len_in  = repeat_len_ff;
      byte_idx_in    = byte_idx_ff;
      partial_in     = partial_ff;
      pix_done       = 1'b0;
      last_idx       = trpd_pkg::last_byte_index(cfg.pixel_format);
      take_byte      = !cfg.rle_enabled || phase_ff == PH_REPEAT || phase_ff == PH_RAW;

      pixel.s0        = partial_ff[7:0];
      pixel.s1        = partial_ff[15:8];
      pixel.s2        = partial_ff[23:16];
      pixel.s3        = data_byte;
      pixel.run_count = 8'd1;
      if (last_idx == 2'd1) begin
         pixel.s1 = data_byte;
      end else if (last_idx == 2'd2) begin
         pixel.s2 = data_byte;
      end
      if (cfg.rle_enabled && phase_ff == PH_REPEAT) begin
         pixel.run_count = repeat_len_ff;
      end

      if (accept) begin
         if (take_byte) begin
            if (byte_idx_ff < last_idx) begin
               case (byte_idx_ff)
                  2'd0:    partial_in[7:0]   = data_byte;
                  2'd1:    partial_in[15:8]  = data_byte;
                  2'd2:    partial_in[23:16] = data_byte;
                  default: ;
               endcase
               byte_idx_in = byte_idx_ff + 2'd1;
            end else begin
               pix_done    = 1'b1;
               byte_idx_in = 2'd0;
               partial_in  = '0;
               if (cfg.rle_enabled) begin
                  phase_in = PH_HEADER;
                  if (phase_ff == PH_RAW && pixels_left_ff > 8'd1) begin
                     phase_in       = PH_RAW;
                     pixels_left_in = pixels_left_ff - 8'd1;
                  end else if (phase_ff == PH_RAW) begin
                     pixels_left_in = 8'd0;
                  end
               end
            end
         end else if (data_byte[7]) begin
            repeat_len_in = {1'b0, data_byte[6:0]} + 8'd1;
            phase_in      = PH_REPEAT;
         end else begin
            pixels_left_in = data_byte + 8'd1;
            phase_in       = PH_RAW;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_HEADER;
         pixels_left_ff <= 8'd0;
         repeat_len_ff  <= 8'd0;
         byte_idx_ff    <= 2'd0;
         partial_ff     <= '0;
      end else begin
         phase_ff       <= phase_in;
         pixels_left_ff <= pixels_left_in;
         repeat_len_ff  <= repeat_len_in;
         byte_idx_ff    <= byte_idx_in;
         partial_ff     <= partial_in;
      end
   end

endmodule

// File: rtl/trpd_convert.sv
// ----------------------------------------------------------------------------
// Pixel converter
// Turns gathered 5-5-5, BGR or BGRA bytes into RGB(A) components.
// ----------------------------------------------------------------------------
module trpd_convert (
   input  trpd_pkg::cfg_type   cfg,
   input  trpd_pkg::pixel_type pixel,
   output trpd_pkg::color_type color
);

   always_comb begin
      color.run_count = pixel.run_count;
      case (cfg.pixel_format)
         trpd_pkg::FMT_RGB555: begin
            color.red   = trpd_pkg::widen5(pixel.s1[6:2]);
            color.green = trpd_pkg::widen5({pixel.s1[1:0], pixel.s0[7:5]});
            color.blue  = trpd_pkg::widen5(pixel.s0[4:0]);
            if (cfg.one_bit_alpha) begin
               color.alpha       = pixel.s1[7] ? 8'd0 : trpd_pkg::ALPHA_OPAQUE;
               color.alpha_valid = 1'b1;
            end else begin
               color.alpha       = 8'd0;
               color.alpha_valid = 1'b0;
            end
         end
         trpd_pkg::FMT_BGR: begin
            color.red         = pixel.s2;
            color.green       = pixel.s1;
            color.blue        = pixel.s0;
            color.alpha       = 8'd0;
            color.alpha_valid = 1'b0;
         end
         default: begin
            color.red         = pixel.s2;
            color.green       = pixel.s1;
            color.blue        = pixel.s0;
            color.alpha       = pixel.s3;
            color.alpha_valid = 1'b1;
         end
      endcase
   end

endmodule

// File: rtl/tga_rle_pixel_decoder_top.sv
// ----------------------------------------------------------------------------
// TGA RLE pixel decoder
// Decodes a truecolor TGA pixel byte stream into RGB(A) pixels with run counts.
// ----------------------------------------------------------------------------
// Usage:
//   req_bus carries one stream byte per transaction: packet headers and pixel
//   bytes in file order. rsp_bus carries one transaction per complete pixel:
//   red, green, blue, alpha, alpha_valid and run_count (1 for raw pixels).
//   Header bytes and non-final pixel bytes give no response.
//   The csr_ port writes rle_enabled, pixel_format and one_bit_alpha; write
//   them only while no transaction is in flight.
//   A response appears the cycle after the final pixel byte is taken. The
//   block takes one byte per cycle while the receiver does not stall, set by
//   the single result register that follows the packet tracker and converter.
//   req_bus.ready stays high while the result register is empty or being
//   drained; a stalled receiver holds the pending pixel and stops input.
//   Reset clears the packet state, empties the result register and restores
//   rle_enabled = 1, pixel_format = 24-bit BGR, one_bit_alpha = 0.
// ----------------------------------------------------------------------------
module tga_rle_pixel_decoder_top (
   input  logic                              clock,
   input  logic                              reset,
   trpd_req_if.sink                          req_bus,
   trpd_rsp_if.source                        rsp_bus,
   input  logic                              csr_wr_en,
   input  logic [trpd_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [trpd_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   trpd_pkg::cfg_type   cfg_ff;
   trpd_pkg::pixel_type pixel;
   trpd_pkg::color_type color;
   trpd_pkg::color_type result_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                accept;
   logic                pix_done;

   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign accept        = req_bus.valid && req_bus.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rle_enabled   <= 1'b1;
         cfg_ff.pixel_format  <= trpd_pkg::FMT_BGR;
         cfg_ff.one_bit_alpha <= 1'b0;
      end else if (csr_wr_en) begin
         case (csr_index)
            trpd_pkg::CSR_RLE_ENABLED:   cfg_ff.rle_enabled   <= csr_wdata[0];
            trpd_pkg::CSR_PIXEL_FORMAT:  cfg_ff.pixel_format  <= csr_wdata[1:0];
            trpd_pkg::CSR_ONE_BIT_ALPHA: cfg_ff.one_bit_alpha <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   trpd_unpack u_unpack (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .accept    (accept),
      .data_byte (req_bus.data_byte),
      .pix_done  (pix_done),
      .pixel     (pixel)
   );

   trpd_convert u_convert (
      .cfg   (cfg_ff),
      .pixel (pixel),
      .color (color)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      if (accept && pix_done) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && pix_done) begin
         result_ff <= color;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.red         = result_ff.red;
   assign rsp_bus.green       = result_ff.green;
   assign rsp_bus.blue        = result_ff.blue;
   assign rsp_bus.alpha       = result_ff.alpha;
   assign rsp_bus.alpha_valid = result_ff.alpha_valid;
   assign rsp_bus.run_count   = result_ff.run_count;

`ifndef SYNTHESIS
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_bus.ready |-> !req_bus.ready)
      else $error("input taken while a pending pixel is stalled");

   a_run_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> result_ff.run_count != 8'd0)
      else $error("pixel with zero run count");

   a_alpha_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !result_ff.alpha_valid |-> result_ff.alpha == 8'd0)
      else $error("alpha set without alpha_valid");

   a_raw_single: assert property (@(posedge clock) disable iff (reset)
      accept && pix_done && !cfg_ff.rle_enabled |=> rsp_valid_ff && result_ff.run_count == 8'd1)
      else $error("raw-mode pixel without single run count");
`endif

endmodule
